// ----- rtl/core/go_back_n_sender_window_defines.svh -----
// Assertion macros for the go-back-n sender window RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GBNSW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbnsw assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GBNSW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbnsw assertion failed");

`endif

// ----- rtl/core/gbnsw_pkg.sv -----
// Package for the go-back-n sender window: widths, codes and shared types.
// No dependencies; every other RTL file but the defines header imports it.
package gbnsw_pkg;

  localparam int SEQ_BITS    = 16;
  localparam int MAX_WINDOW  = 8;
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int IDX_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_BITS    = 4;
  localparam int TMO_BITS    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TMO_BITS-1:0] TMO_MAX = 4'd15;

  // Command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_ROUND = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_WAIT  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  typedef struct packed {
    logic [SEQ_BITS-1:0] total_packets;
    logic [WIN_BITS-1:0] win_size;
    logic [TMO_BITS-1:0] timeout_limit;
  } cfg_t;

  // One job: a single status result, or a burst of count sends from seq.
  typedef struct packed {
    logic [1:0]          kind;
    logic [SEQ_BITS-1:0] seq;
    logic [CNT_BITS-1:0] count;
    logic                retx;
  } job_t;

endpackage

// ----- rtl/core/gbnsw_cmd_if.sv -----
// Channel interfaces for commands in and results out.
// Depends on gbnsw_pkg for field widths.
interface gbnsw_cmd_if import gbnsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SEQ_BITS-1:0] ack_seq;

  modport source (output valid, command, ack_seq, input ready);
  modport sink   (input valid, command, ack_seq, output ready);
endinterface

interface gbnsw_res_if import gbnsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [SEQ_BITS-1:0] send_seq;
  logic                retransmit;
  logic                last;

  modport source (output valid, kind, send_seq, retransmit, last, input ready);
  modport sink   (input valid, kind, send_seq, retransmit, last, output ready);
endinterface

// ----- rtl/core/gbnsw_front.sv -----
// Front end: accepts commands, keeps the window state and emits one job per item.
// Depends on gbnsw_pkg and the command channel interface.
module gbnsw_front import gbnsw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gbnsw_cmd_if.sink    cmd,
  input  cfg_t         cfg,
  input  logic         q_ready,
  output logic         push,
  output job_t         job
);

  logic [SEQ_BITS-1:0] base, base_next;
  logic [SEQ_BITS-1:0] nxt, nxt_next;
  logic [TMO_BITS-1:0] tcnt, tcnt_next;
  logic                ackr, ackr_next;
  logic                rew, rew_next;
  logic                act, act_next;

  logic                is_start;
  logic [TMO_BITS-1:0] tmo_inc;
  logic [CNT_BITS-1:0] win;
  logic [SEQ_BITS-1:0] adv_base, adv_next, lim, diff;
  logic [SEQ_BITS:0]   lim_wide, nb_wide;
  logic [SEQ_BITS-1:0] nb;
  logic                adv_rew, do_adv;

  assign cmd.ready = q_ready;
  assign push      = cmd.valid && q_ready;
  assign is_start  = (cmd.command == CMD_START);

  always_comb begin
    tmo_inc  = (tcnt < TMO_MAX) ? tcnt + 1'b1 : tcnt;
    win      = ({{(32-WIN_BITS){1'b0}}, cfg.win_size} > MAX_WINDOW)
               ? CNT_BITS'(MAX_WINDOW) : CNT_BITS'(cfg.win_size);
    // Window start after this item; a missed ack rewinds to the base.
    adv_base = is_start ? '0 : base;
    adv_next = is_start ? '0 : (!ackr ? base : nxt);
    adv_rew  = is_start ? 1'b0 : (!ackr || rew);
    lim_wide = {1'b0, adv_base} + (SEQ_BITS+1)'(win);
    lim      = (lim_wide > {1'b0, cfg.total_packets}) ? cfg.total_packets
                                                      : lim_wide[SEQ_BITS-1:0];
    diff     = lim - adv_next;
    nb_wide  = {1'b0, cmd.ack_seq} + 1'b1;
    nb       = (nb_wide > {1'b0, cfg.total_packets}) ? cfg.total_packets
                                                     : nb_wide[SEQ_BITS-1:0];
  end

  always_comb begin
    base_next = base;
    nxt_next  = nxt;
    tcnt_next = tcnt;
    ackr_next = ackr;
    rew_next  = rew;
    act_next  = act;
    do_adv    = 1'b0;
    job       = '{kind: KIND_WAIT, seq: '0, count: CNT_BITS'(1), retx: 1'b0};
    if (push) begin
      priority if (is_start) begin
        base_next = '0;
        tcnt_next = '0;
        ackr_next = 1'b0;
        rew_next  = 1'b0;
        act_next  = 1'b1;
        do_adv    = 1'b1;
      end else if (cmd.command == CMD_ACK) begin
        if (act && cmd.ack_seq >= base) begin
          base_next = nb;
          nxt_next  = (nxt < nb) ? nb : nxt;
          tcnt_next = '0;
          ackr_next = 1'b1;
          rew_next  = 1'b0;
        end
      end else if (cmd.command == CMD_ROUND && act) begin
        ackr_next = 1'b0;
        if (!ackr) begin
          tcnt_next = tmo_inc;
          if (tmo_inc >= cfg.timeout_limit) begin
            act_next = 1'b0;
            job.kind = KIND_ABORT;
          end else begin
            rew_next = 1'b1;
            do_adv   = 1'b1;
          end
        end else begin
          do_adv = 1'b1;
        end
      end else begin
        // The unused code and a round end while idle get the default waiting job.
      end
      if (do_adv) begin
        nxt_next = adv_next;
        if (adv_base >= cfg.total_packets) begin
          act_next = 1'b0;
          job.kind = KIND_DONE;
        end else if (adv_next < lim) begin
          job.kind  = KIND_SEND;
          job.seq   = adv_next;
          job.count = diff[CNT_BITS-1:0];
          job.retx  = adv_rew;
          nxt_next  = lim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      nxt  <= '0;
      tcnt <= '0;
      ackr <= 1'b0;
      rew  <= 1'b0;
      act  <= 1'b0;
    end else begin
      base <= base_next;
      nxt  <= nxt_next;
      tcnt <= tcnt_next;
      ackr <= ackr_next;
      rew  <= rew_next;
      act  <= act_next;
    end
  end

endmodule

// ----- rtl/core/gbnsw_queue.sv -----
// Short job queue between the front end and the result sequencer.
// Depends on gbnsw_pkg for the job type and depth.
module gbnsw_queue import gbnsw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic not_full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FILL_BITS-1:0] fill;

  assign not_full   = (fill != FILL_BITS'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + FILL_BITS'(push) - FILL_BITS'(pop);
    end
  end

endmodule

// ----- rtl/core/gbnsw_back.sv -----
// Back end: expands each job into result items, one per cycle unless stalled, into an output register.
// Depends on gbnsw_pkg and the result channel interface.
module gbnsw_back import gbnsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  gbnsw_res_if.source res
);

  logic [IDX_BITS-1:0] idx;
  logic                load, is_last;
  logic                out_valid;

  assign load    = head_valid && (!out_valid || res.ready);
  assign is_last = ({{(32-IDX_BITS){1'b0}}, idx} + 1 == {{(32-CNT_BITS){1'b0}}, head_job.count});
  assign pop     = load && is_last;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.kind       <= head_job.kind;
      res.send_seq   <= head_job.seq + SEQ_BITS'(idx);
      res.retransmit <= head_job.retx;
      res.last       <= is_last;
    end
  end

endmodule

// ----- rtl/core/go_back_n_sender_window.sv -----
// Top level of the go-back-n sender window: register port, front end, queue, back end.
// Depends on gbnsw_pkg, the channel interfaces, the submodules and the defines header.
//
// Usage. Commands arrive on the cmd channel (start, cumulative ack, round end),
// one item per valid/ready handshake. Results leave on the res channel: each
// command yields one status item (waiting, done or aborted), or a round of send
// requests with last set on the final one. total_packets, the window size and
// timeout_limit are written over the APB port at byte addresses 0, 4 and 8 while
// the block is idle; reads return the stored values.
// A command becomes a job in the queue, then its results pass the output register.
// A command yields 1 to 8 results, 8 for a full window; the back end emits one
// per cycle unless the receiver holds res.ready low.
// The front end can run up to two commands ahead, bounded by the two-entry job
// queue, so commands are taken while results still drain.
// Reset (rst, synchronous) makes the transfer idle, clears the window state and
// restores the registers to 1, 8 and 15. When the receiver holds res.ready low,
// the output register keeps its item, the queue fills, and cmd.ready drops.
`include "go_back_n_sender_window_defines.svh"

module go_back_n_sender_window import gbnsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gbnsw_cmd_if.sink   cmd,
  gbnsw_res_if.source res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_TOTAL   = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  cfg_t cfg;
  logic wr_en;
  logic q_ready, push, pop, head_valid;
  job_t push_job, head_job;

  // Register port: writes land on the access phase; pready is tied high.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_packets <= SEQ_BITS'(1);
      cfg.win_size      <= WIN_BITS'(8);
      cfg.timeout_limit <= TMO_BITS'(15);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TOTAL:   cfg.total_packets <= pwdata[SEQ_BITS-1:0];
        REG_WINDOW:  cfg.win_size      <= pwdata[WIN_BITS-1:0];
        REG_TIMEOUT: cfg.timeout_limit <= pwdata[TMO_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TOTAL:   prdata = {{(32-SEQ_BITS){1'b0}}, cfg.total_packets};
      REG_WINDOW:  prdata = {{(32-WIN_BITS){1'b0}}, cfg.win_size};
      REG_TIMEOUT: prdata = {{(32-TMO_BITS){1'b0}}, cfg.timeout_limit};
      default:     prdata = '0;
    endcase
  end

  // The front end decides everything about a command in the cycle it is taken
  // and hands the back end a compact job: a status code or a run of sends.
  gbnsw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .q_ready (q_ready),
    .push    (push),
    .job     (push_job)
  );

  gbnsw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .not_full   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back end walks a job one result per cycle unless res.ready stalls it, and owns the output register.
  gbnsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res        (res)
  );

  // A status result is always the only result of its command.
  `GBNSW_ASSERT_NOW(a_status_is_last, clk, rst, res.valid && res.kind != KIND_SEND, res.last)
  // Status results carry no sequence and no retransmit mark.
  `GBNSW_ASSERT_NOW(a_status_clean, clk, rst, res.valid && res.kind != KIND_SEND,
                    res.send_seq == '0 && !res.retransmit)
  // Every job queued by the front end produces between one and a full window of results.
  `GBNSW_ASSERT_NOW(a_job_count, clk, rst, push,
                    push_job.count != '0 && push_job.count <= CNT_BITS'(MAX_WINDOW))
  // A job at the queue head is taken as soon as the output register is free.
  `GBNSW_ASSERT_NXT(a_back_moves, clk, rst, head_valid && !res.valid, res.valid)

endmodule

// ----- sim/go_back_n_sender_window_tb.sv -----
// Self-checking testbench for the go-back-n sender window.
// Depends on gbnsw_pkg, the channel interfaces and the go_back_n_sender_window RTL.
module go_back_n_sender_window_tb;
  import gbnsw_pkg::*;

  localparam int CLK_PERIOD = 8;

  // Command code 3 has no meaning; the block must answer it with a waiting item.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Register indexes of the APB port; byte address is four times the index.
  localparam logic [1:0] REG_TOTAL   = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Cycles a result may still take after the last expected one has arrived.
  localparam int SETTLE_CYCLES = 12;

  // Length of the receiver hold-off that fills the block up.
  localparam int LONG_HOLD_CYCLES = 80;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SEQ_BITS-1:0] seq;
    logic                retx;
    logic                last;
  } gbn_result_t;

  // The scoreboard mirrors the sender state and keeps the results that each
  // accepted command should produce, oldest first.
  class window_scoreboard;
    logic [SEQ_BITS-1:0] cfg_total;
    logic [WIN_BITS-1:0] cfg_window;
    logic [TMO_BITS-1:0] cfg_limit;

    logic [SEQ_BITS-1:0] base_seq;
    logic [SEQ_BITS-1:0] next_seq;
    logic [TMO_BITS-1:0] miss_count;
    bit                  acked_in_round;
    bit                  in_rewind;
    bit                  busy;

    gbn_result_t pending_results[$];

    int errors;
    int commands;
    int results;
    int sends;
    int retransmits;
    int dones;
    int aborts;

    function new();
      cfg_total      = 16'd1;
      cfg_window     = 4'd8;
      cfg_limit      = 4'd15;
      base_seq       = '0;
      next_seq       = '0;
      miss_count     = '0;
      acked_in_round = 1'b0;
      in_rewind      = 1'b0;
      busy           = 1'b0;
      errors         = 0;
      commands       = 0;
      results        = 0;
      sends          = 0;
      retransmits    = 0;
      dones          = 0;
      aborts         = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_TOTAL:   cfg_total  = value[SEQ_BITS-1:0];
        REG_WINDOW:  cfg_window = value[WIN_BITS-1:0];
        REG_TIMEOUT: cfg_limit  = value[TMO_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void push_result(logic [1:0] kind, logic [SEQ_BITS-1:0] seq, logic retx,
                              logic last);
      gbn_result_t r;
      r.kind = kind;
      r.seq  = seq;
      r.retx = retx;
      r.last = last;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Either the transfer is done, every sequence that fits the window is requested, or a waiting item is queued.
    function void push_round();
      logic [SEQ_BITS:0]   edge_seq;
      logic [WIN_BITS-1:0] win;
      int                  count;
      if (base_seq >= cfg_total) begin
        busy = 1'b0;
        push_result(KIND_DONE, '0, 1'b0, 1'b1);
        return;
      end
      win = (cfg_window > MAX_WINDOW) ? WIN_BITS'(MAX_WINDOW) : cfg_window;
      edge_seq = base_seq + win;
      if (edge_seq > {1'b0, cfg_total}) edge_seq = {1'b0, cfg_total};
      count = (next_seq < edge_seq) ? int'(edge_seq - next_seq) : 0;
      if (count > MAX_WINDOW) count = MAX_WINDOW;
      if (count == 0) begin
        push_result(KIND_WAIT, '0, 1'b0, 1'b1);
        return;
      end
      for (int i = 0; i < count; i++) begin
        push_result(KIND_SEND, next_seq, in_rewind, i == count - 1);
        next_seq = next_seq + 1'b1;
      end
    endfunction

    function void note_command(logic [1:0] cmd, logic [SEQ_BITS-1:0] ack);
      logic [SEQ_BITS:0] new_base;
      commands++;
      if (cmd == CMD_START) begin
        base_seq       = '0;
        next_seq       = '0;
        miss_count     = '0;
        acked_in_round = 1'b0;
        in_rewind      = 1'b0;
        busy           = 1'b1;
        push_round();
        return;
      end
      if (cmd == CMD_ACK) begin
        if (busy && ack >= base_seq) begin
          new_base = ack + 17'd1;
          if (new_base > {1'b0, cfg_total}) new_base = {1'b0, cfg_total};
          base_seq = new_base[SEQ_BITS-1:0];
          if (next_seq < base_seq) next_seq = base_seq;
          miss_count     = '0;
          acked_in_round = 1'b1;
          in_rewind      = 1'b0;
        end
        push_result(KIND_WAIT, '0, 1'b0, 1'b1);
        return;
      end
      if (cmd == CMD_ROUND && busy) begin
        if (!acked_in_round) begin
          if (miss_count < TMO_MAX) miss_count = miss_count + 1'b1;
          if (miss_count >= cfg_limit) begin
            busy           = 1'b0;
            acked_in_round = 1'b0;
            push_result(KIND_ABORT, '0, 1'b0, 1'b1);
            return;
          end
          next_seq  = base_seq;
          in_rewind = 1'b1;
        end
        acked_in_round = 1'b0;
        push_round();
        return;
      end
      push_result(KIND_WAIT, '0, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, logic [SEQ_BITS-1:0] exp_v,
                                logic [SEQ_BITS-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
                   $time, results, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [SEQ_BITS-1:0] seq, logic retx,
                               logic last);
      gbn_result_t e;
      results++;
      if (kind == KIND_SEND) sends++;
      if (kind == KIND_SEND && retx) retransmits++;
      if (kind == KIND_DONE) dones++;
      if (kind == KIND_ABORT) aborts++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result: expected none, got kind %0d seq %0d", $time,
                   kind, seq);
        return;
      end
      e = pending_results.pop_front();
      compare_field("kind", SEQ_BITS'(e.kind), SEQ_BITS'(kind));
      compare_field("send_seq", e.seq, seq);
      compare_field("retransmit", SEQ_BITS'(e.retx), SEQ_BITS'(retx));
      compare_field("last", SEQ_BITS'(e.last), SEQ_BITS'(last));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gbnsw_cmd_if cmd_ch ();
  gbnsw_res_if res_ch ();

  go_back_n_sender_window uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  window_scoreboard sb = new();

  // Idling controls shared between the stimulus and the result receiver.
  // A quiet flag turns off the random gaps on that side for a whole phase.
  bit in_quiet;
  bit out_quiet;
  int hold_request;
  int settings_applied;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a correct run ends long before this.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("%0t: timeout with %0d results still expected", $time, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one command and returns at the edge where it is accepted. Valid is
  // lowered only when a gap is drawn, so back-to-back items keep it high.
  task automatic drive_command(input logic [1:0] cmd, input logic [SEQ_BITS-1:0] ack);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.ack_seq <= ack;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(cmd, ack);
  endtask

  // Stops offering commands and waits until every expected result has been seen.
  // At least one edge always passes, so a later valid is never set in the same step.
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // APB write with a setup and an access phase, then a read back of the register.
  // The bus is then left idle so that the next transfer starts cleanly.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      sb.errors++;
      $display("%0t: register %0d read back: expected %0h, got %0h", $time, idx, value,
               prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the block has drained and settled.
  task automatic apply_settings(input logic [SEQ_BITS-1:0] total,
                                input logic [WIN_BITS-1:0] win,
                                input logic [TMO_BITS-1:0] limit);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_TOTAL, 32'(total));
    write_register(REG_WINDOW, 32'(win));
    write_register(REG_TIMEOUT, 32'(limit));
    settings_applied++;
  endtask

  // Picks a command the way a real sender would issue them: start when idle,
  // cumulative acks that land around the current window, and round ends. A
  // small share is noise: unused codes, random acks and commands while idle.
  task automatic random_command();
    int               pick;
    int               lo;
    logic [1:0]       cmd;
    logic [SEQ_BITS-1:0] ack;
    pick = $urandom_range(0, 99);
    ack  = SEQ_BITS'($urandom_range(0, 65535));
    if (!sb.busy) begin
      cmd = (pick < 80) ? CMD_START : 2'($urandom_range(1, 3));
    end else if (pick < 3) begin
      cmd = CMD_START;
    end else if (pick < 7) begin
      cmd = 2'($urandom_range(1, 3));
    end else if (pick < 52) begin
      cmd = CMD_ACK;
      lo  = (sb.base_seq > 0) ? int'(sb.base_seq) - 1 : 0;
      ack = SEQ_BITS'($urandom_range(lo, int'(sb.next_seq)));
    end else begin
      cmd = CMD_ROUND;
    end
    drive_command(cmd, ack);
  endtask

  // One phase of random traffic under a single register setting. With pressure
  // on, the receiver first holds off for a long stretch while commands keep
  // coming, and halfway through the sender stops until all results are in.
  task automatic run_phase(input logic [SEQ_BITS-1:0] total, input logic [WIN_BITS-1:0] win,
                           input logic [TMO_BITS-1:0] limit, input int items,
                           input bit quiet_in, input bit quiet_out, input bit pressure);
    apply_settings(total, win, limit);
    in_quiet  = quiet_in;
    out_quiet = quiet_out;
    if (pressure) hold_request = LONG_HOLD_CYCLES;
    for (int i = 0; i < items; i++) begin
      if (pressure && i == items / 2) wait_for_results();
      random_command();
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  // Result receiver. Each item gets its own random stall, or the
  // long hold-off when one has been requested. Ready is lowered only for a
  // stall, so a run of accepted results keeps it high.
  initial begin : result_receiver
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = out_quiet ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      sb.check_result(res_ch.kind, res_ch.send_seq, res_ch.retransmit, res_ch.last);
    end
  end

  initial begin : stimulus
    in_quiet         = 1'b0;
    out_quiet        = 1'b0;
    hold_request     = 0;
    settings_applied = 0;

    // Every input is known from time zero; reset is held, then released.
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_START;
    cmd_ch.ack_seq <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first with the reset values of the registers.
    // Commands while idle and the unused code are all ignored.
    drive_command(CMD_ROUND, 16'd0);
    drive_command(CMD_ACK, 16'd0);
    drive_command(CMD_UNUSED, 16'hFFFF);
    // A one-packet transfer: one send, its ack, then done at the round end.
    drive_command(CMD_START, 16'd0);
    drive_command(CMD_ACK, 16'd0);
    drive_command(CMD_ROUND, 16'd0);

    // Full window of eight, restart while active, an ack and a stale ack,
    // a round with an ack, a timeout with rewind, a saturating ack and done.
    apply_settings(16'd20, 4'd8, 4'd2);
    drive_command(CMD_START, 16'd0);
    drive_command(CMD_START, 16'd0);
    drive_command(CMD_ACK, 16'd3);
    drive_command(CMD_ACK, 16'd2);
    drive_command(CMD_ROUND, 16'd0);
    drive_command(CMD_ROUND, 16'd0);
    drive_command(CMD_ACK, 16'hFFFF);
    drive_command(CMD_ROUND, 16'd0);
    // Two ackless rounds in a row reach the limit of two and abort.
    drive_command(CMD_START, 16'd0);
    drive_command(CMD_ROUND, 16'd0);
    drive_command(CMD_ROUND, 16'd0);

    // An empty transfer is done at once and leaves the block idle.
    apply_settings(16'd0, 4'd5, 4'd0);
    drive_command(CMD_START, 16'd0);

    // A zero window never sends, and a zero limit aborts on the first miss.
    apply_settings(16'd5, 4'd0, 4'd0);
    drive_command(CMD_START, 16'd0);
    drive_command(CMD_ROUND, 16'd0);

    // The largest transfer with an oversized window, which is clamped to eight;
    // acks near the top of the sequence space, and the base saturates.
    apply_settings(16'hFFFF, 4'd15, 4'd15);
    drive_command(CMD_START, 16'd0);
    drive_command(CMD_ACK, 16'hFFFD);
    drive_command(CMD_ROUND, 16'd0);
    drive_command(CMD_ACK, 16'hFFFF);
    drive_command(CMD_ROUND, 16'd0);

    // Random part over a range of settings, the extremes among them.
    run_phase(16'd12, 4'd4, 4'd3, 54, 1'b0, 1'b0, 1'b0);
    run_phase(16'd1, 4'd1, 4'd1, 54, 1'b1, 1'b1, 1'b0);
    run_phase(16'd30, 4'd8, 4'd15, 54, 1'b0, 1'b0, 1'b1);
    run_phase(16'hFFFF, 4'd8, 4'd4, 54, 1'b1, 1'b0, 1'b0);
    run_phase(16'd40, 4'd15, 4'd2, 54, 1'b0, 1'b1, 1'b0);
    for (int p = 0; p < 3; p++)
      run_phase(16'($urandom_range(1, 40)), 4'($urandom_range(1, 15)),
                4'($urandom_range(0, 15)), 54, 1'b0, 1'b0, 1'b0);

    // Drain, then leave room for any stray result to show up.
    wait_for_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Covered %0d commands and %0d results under %0d register settings.",
             sb.commands, sb.results, settings_applied);
    $display("Results seen: %0d sends (%0d retransmitted), %0d done, %0d aborted.",
             sb.sends, sb.retransmits, sb.dones, sb.aborts);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors found", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/gbnsw_pkg.sv
rtl/core/gbnsw_cmd_if.sv
rtl/core/gbnsw_front.sv
rtl/core/gbnsw_queue.sv
rtl/core/gbnsw_back.sv
rtl/core/go_back_n_sender_window.sv
sim/go_back_n_sender_window_tb.sv
